@@ rtl/lrup_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LRU pool package
// Shared sizes, codes and types of the pinned-entry LRU pool.
// ----------------------------------------------------------------------------
package lrup_pkg;

	// Pool geometry and stamp width.
	localparam int POOL_DEPTH = 16;
	localparam int TICK_BITS  = 32;
	localparam int KEY_BITS   = 64;
	localparam int IDX_W      = $clog2(POOL_DEPTH);

	// Two stamps count as ordered while their distance stays below this value.
	localparam logic [TICK_BITS-1:0] TICK_HALF = {1'b0, {(TICK_BITS-1){1'b1}}};

	// Operation codes of the command word.
	localparam logic OP_LOOKUP = 1'b0;
	localparam logic OP_INSERT = 1'b1;

	// Result status codes.
	typedef enum logic [1:0] {
		STATUS_OK      = 2'd0,
		STATUS_MISS    = 2'd1,
		STATUS_REFUSED = 2'd2
	} status_t;

	// Sequencer states.
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_WALK,
		ST_DRAIN,
		ST_COMMIT
	} state_t;

	// Control of the scan unit for one entry read back from the memories.
	typedef struct packed {
		logic             clear;
		logic             en;
		logic [IDX_W-1:0] idx;
		logic             valid;
		logic             pinned;
	} scan_ctl_t;

	// What the scan found after a full walk of the pool.
	typedef struct packed {
		logic                match_found;
		logic [IDX_W-1:0]    match_idx;
		logic                free_found;
		logic [IDX_W-1:0]    free_idx;
		logic                vic_found;
		logic [IDX_W-1:0]    vic_idx;
		logic [KEY_BITS-1:0] vic_key;
	} scan_res_t;

endpackage

@@ rtl/lru_pool_with_pinned_entries.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LRU pool with pinned entries
// Fully associative pool of keyed entries with last-use stamps; lookups touch
// a hit, inserts fill a free slot or evict the oldest unpinned entry, else are refused.
// ----------------------------------------------------------------------------
// A word taken at a start edge has every entry read through the one read port of
// the key and stamp memories in ST_WALK, the last read drained in ST_DRAIN, the
// entry written back in ST_COMMIT with its result word registered there, and the
// result word then shown on the ports with done.
// The block takes one word at a time; busy is high from accept to write-back.
// Reset empties the pool and clears the tick; no clearing pass is needed.
// The result is shown for one cycle only; the receiver cannot stall it.
module lru_pool_with_pinned_entries (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  logic                          operation,
	input  logic [lrup_pkg::KEY_BITS-1:0] key,
	input  logic                          pin,
	output logic                          done,
	output logic                          hit,
	output logic [3:0]                    slot,
	output logic                          evicted,
	output logic [lrup_pkg::KEY_BITS-1:0] evicted_key,
	output logic [1:0]                    status
);
	import lrup_pkg::*;

	state_t state_q, state_d;

	// Command word held for the whole walk.
	logic                 op_q;
	logic [KEY_BITS-1:0]  key_q;
	logic                 pin_q;

	// Per-entry flags in flip-flops; keys and stamps in memories.
	logic [POOL_DEPTH-1:0] valid_q;
	logic [POOL_DEPTH-1:0] pinned_q;
	logic [KEY_BITS-1:0]   key_mem   [POOL_DEPTH];
	logic [TICK_BITS-1:0]  stamp_mem [POOL_DEPTH];
	logic [TICK_BITS-1:0]  tick_q;

	// Walk address and the read stage behind it.
	logic [IDX_W-1:0]     rd_idx_q;
	logic                 rd_en;
	logic                 en_s1;
	logic [IDX_W-1:0]     idx_s1;
	logic [KEY_BITS-1:0]  rd_key_s1;
	logic [TICK_BITS-1:0] rd_stamp_s1;

	scan_ctl_t scan_ctl;
	scan_res_t scan_res;

	// Commit decisions.
	logic                 accept;
	logic                 commit;
	logic                 wr_en;
	logic                 wr_key_en;
	logic [IDX_W-1:0]     wr_idx;
	logic [TICK_BITS-1:0] tick_nxt;
	logic                 res_hit;
	logic                 res_evicted;
	logic [KEY_BITS-1:0]  res_ekey;
	status_t              res_status;

	logic                 done_q;
	logic                 hit_q;
	logic [3:0]           slot_q;
	logic                 evicted_q;
	logic [KEY_BITS-1:0]  evicted_key_q;
	status_t              status_q;

	assign accept   = start && (state_q == ST_IDLE);
	assign busy     = (state_q != ST_IDLE);
	assign tick_nxt = tick_q + 1'b1;

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state and walk read enable.
	always_comb begin
		state_d = state_q;
		rd_en   = 1'b0;
		commit  = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (start) state_d = ST_WALK;
			end
			ST_WALK: begin
				rd_en = 1'b1;
				if (rd_idx_q == IDX_W'(POOL_DEPTH - 1)) state_d = ST_DRAIN;
			end
			ST_DRAIN: begin
				state_d = ST_COMMIT;
			end
			ST_COMMIT: begin
				commit  = 1'b1;
				state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// Capture the command word.
	always_ff @(posedge clk) begin
		if (accept) begin
			op_q  <= operation;
			key_q <= key;
			pin_q <= pin;
		end
	end

	// Walk address counter and read-stage valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_idx_q <= '0;
			en_s1    <= 1'b0;
		end else begin
			en_s1 <= rd_en;
			if (accept) begin
				rd_idx_q <= '0;
			end else if (rd_en) begin
				rd_idx_q <= rd_idx_q + 1'b1;
			end
		end
	end

	// Key and stamp memories: one registered read, one write per cycle.
	always_ff @(posedge clk) begin
		idx_s1      <= rd_idx_q;
		rd_key_s1   <= key_mem[rd_idx_q];
		rd_stamp_s1 <= stamp_mem[rd_idx_q];
		if (wr_key_en) key_mem[wr_idx] <= key_q;
		if (wr_en)     stamp_mem[wr_idx] <= tick_nxt;
	end

	assign scan_ctl.clear  = accept;
	assign scan_ctl.en     = en_s1;
	assign scan_ctl.idx    = idx_s1;
	assign scan_ctl.valid  = valid_q[idx_s1];
	assign scan_ctl.pinned = pinned_q[idx_s1];

	lrup_scan u_scan (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctl      (scan_ctl),
		.want_key (key_q),
		.rd_key   (rd_key_s1),
		.rd_stamp (rd_stamp_s1),
		.res      (scan_res)
	);

	// Decide the outcome once the walk is complete.
	always_comb begin
		wr_en       = 1'b0;
		wr_key_en   = 1'b0;
		wr_idx      = scan_res.match_idx;
		res_hit     = 1'b0;
		res_evicted = 1'b0;
		res_ekey    = '0;
		res_status  = STATUS_OK;
		if (scan_res.match_found) begin
			wr_en   = commit;
			res_hit = 1'b1;
		end else if (op_q == OP_LOOKUP) begin
			res_status = STATUS_MISS;
		end else if (scan_res.free_found) begin
			wr_en     = commit;
			wr_key_en = commit;
			wr_idx    = scan_res.free_idx;
		end else if (scan_res.vic_found) begin
			wr_en       = commit;
			wr_key_en   = commit;
			wr_idx      = scan_res.vic_idx;
			res_evicted = 1'b1;
			res_ekey    = scan_res.vic_key;
		end else begin
			res_status = STATUS_REFUSED;
		end
	end

	// Tick, valid and pinned flags update on commit.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tick_q   <= '0;
			valid_q  <= '0;
			pinned_q <= '0;
		end else if (wr_en) begin
			tick_q <= tick_nxt;
			if (wr_key_en) begin
				valid_q[wr_idx]  <= 1'b1;
				pinned_q[wr_idx] <= pin_q;
			end else if (op_q == OP_INSERT) begin
				pinned_q[wr_idx] <= pinned_q[wr_idx] | pin_q;
			end
		end
	end

	// Result word registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= commit;
		end
	end

	always_ff @(posedge clk) begin
		if (commit) begin
			hit_q         <= res_hit;
			slot_q        <= (wr_en) ? 4'(wr_idx) : 4'd0;
			evicted_q     <= res_evicted;
			evicted_key_q <= res_ekey;
			status_q      <= res_status;
		end
	end

	assign done        = done_q;
	assign hit         = hit_q;
	assign slot        = slot_q;
	assign evicted     = evicted_q;
	assign evicted_key = evicted_key_q;
	assign status      = status_q;

	// A result word is a single-cycle pulse.
	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done) else $error("done held for more than one cycle");

	// A result only follows the write-back cycle.
	a_done_after_commit: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(state_q) == ST_COMMIT) else $error("done without commit");

	// An accepted word makes the block busy.
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy) else $error("accepted word did not start a walk");

	// An eviction is never a hit and always completes.
	a_evict_clean: assert property (@(posedge clk) disable iff (!arst_n)
		(done && evicted) |-> (!hit && status == STATUS_OK))
		else $error("eviction reported with a hit or a failure");

	// A refused insert reports neither a hit nor an eviction.
	a_refused_clean: assert property (@(posedge clk) disable iff (!arst_n)
		(done && status == STATUS_REFUSED) |-> (!hit && !evicted && slot == 4'd0))
		else $error("refused insert reported a slot");

endmodule

@@ rtl/lrup_scan.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LRU pool scan unit
// Looks at one entry per enabled cycle and keeps the first key match, the first free
// slot and the oldest unpinned entry seen so far.
// ----------------------------------------------------------------------------
module lrup_scan (
	input  logic                            clk,
	input  logic                            arst_n,
	input  lrup_pkg::scan_ctl_t             ctl,
	input  logic [lrup_pkg::KEY_BITS-1:0]   want_key,
	input  logic [lrup_pkg::KEY_BITS-1:0]   rd_key,
	input  logic [lrup_pkg::TICK_BITS-1:0]  rd_stamp,
	output lrup_pkg::scan_res_t             res
);
	import lrup_pkg::*;

	logic                 match_found_q;
	logic [IDX_W-1:0]     match_idx_q;
	logic                 free_found_q;
	logic [IDX_W-1:0]     free_idx_q;
	logic                 vic_found_q;
	logic [IDX_W-1:0]     vic_idx_q;
	logic [KEY_BITS-1:0]  vic_key_q;
	logic [TICK_BITS-1:0] vic_stamp_q;

	logic                 is_match;
	logic                 is_free;
	logic                 is_cand;
	logic [TICK_BITS-1:0] age_diff;
	logic                 take_vic;

	// Classify the entry that is on the read port this cycle.
	always_comb begin
		is_match = ctl.en && ctl.valid && (rd_key == want_key) && !match_found_q;
		is_free  = ctl.en && !ctl.valid && !free_found_q;
		is_cand  = ctl.en && ctl.valid && !ctl.pinned;
		age_diff = rd_stamp - vic_stamp_q;
		take_vic = is_cand && (!vic_found_q || (age_diff >= TICK_HALF));
	end

	// Running results; cleared when a new command word is taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			match_found_q <= 1'b0;
			free_found_q  <= 1'b0;
			vic_found_q   <= 1'b0;
		end else if (ctl.clear) begin
			match_found_q <= 1'b0;
			free_found_q  <= 1'b0;
			vic_found_q   <= 1'b0;
		end else begin
			if (is_match) match_found_q <= 1'b1;
			if (is_free)  free_found_q  <= 1'b1;
			if (take_vic) vic_found_q   <= 1'b1;
		end
	end

	// Slot indexes, victim key and victim stamp carry no reset.
	always_ff @(posedge clk) begin
		if (is_match) match_idx_q <= ctl.idx;
		if (is_free)  free_idx_q  <= ctl.idx;
		if (take_vic) begin
			vic_idx_q   <= ctl.idx;
			vic_key_q   <= rd_key;
			vic_stamp_q <= rd_stamp;
		end
	end

	assign res.match_found = match_found_q;
	assign res.match_idx   = match_idx_q;
	assign res.free_found  = free_found_q;
	assign res.free_idx    = free_idx_q;
	assign res.vic_found   = vic_found_q;
	assign res.vic_idx     = vic_idx_q;
	assign res.vic_key     = vic_key_q;

endmodule

@@ tb/sv/testbench.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LRU pool with pinned entries: testbench
// Sends lookup and insert command words with random gaps, predicts every
// result word from an internal copy of the pool, and checks each result word
// field by field as it comes out.
// ----------------------------------------------------------------------------
module testbench;
	import lrup_pkg::*;

	localparam int CLK_HALF     = 5;
	localparam int CYCLE_LIMIT  = 600000;
	localparam int DRAIN_CYCLES = 40;
	localparam int RANDOM_WORDS = 1300;
	localparam int PIN_WORDS    = 200;
	localparam int WSET         = 24;

	// One command word waiting to be sent, with the idle gap that precedes it.
	typedef struct {
		logic                op;
		logic [KEY_BITS-1:0] key;
		logic                pin;
		int                  gap;
	} cmd_t;

	// One predicted result word.
	typedef struct {
		logic                hit;
		logic [3:0]          slot;
		logic                evicted;
		logic [KEY_BITS-1:0] evicted_key;
		status_t             status;
	} result_t;

	logic                clk         = 1'b0;
	logic                arst_n      = 1'b0;
	logic                start       = 1'b0;
	logic                operation   = OP_LOOKUP;
	logic [KEY_BITS-1:0] key         = '0;
	logic                pin         = 1'b0;
	logic                busy;
	logic                done;
	logic                hit;
	logic [3:0]          slot;
	logic                evicted;
	logic [KEY_BITS-1:0] evicted_key;
	logic [1:0]          status;

	// Shadow copy of the pool contents.
	logic                 pool_valid  [POOL_DEPTH];
	logic [KEY_BITS-1:0]  pool_key    [POOL_DEPTH];
	logic [TICK_BITS-1:0] pool_stamp  [POOL_DEPTH];
	logic                 pool_pinned [POOL_DEPTH];
	logic [TICK_BITS-1:0] pool_tick;

	cmd_t    cmd_queue[$];
	result_t awaited_results[$];

	logic no_idle = 1'b0;
	int   idle_left = 0;
	int   n_accepted = 0;
	int   n_errors = 0;
	int   n_cycles = 0;
	int   n_hits = 0;
	int   n_misses = 0;
	int   n_evictions = 0;
	int   n_refused = 0;

	lru_pool_with_pinned_entries DUT (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.busy       (busy),
		.operation  (operation),
		.key        (key),
		.pin        (pin),
		.done       (done),
		.hit        (hit),
		.slot       (slot),
		.evicted    (evicted),
		.evicted_key(evicted_key),
		.status     (status)
	);

	// Free-running clock.
	always #CLK_HALF clk = ~clk;

	// Apply one command word to the shadow pool and return the result it causes.
	function automatic result_t pool_access(logic op, logic [KEY_BITS-1:0] k, logic p);
		result_t              r;
		int                   found;
		int                   victim;
		logic [TICK_BITS-1:0] oldest;
		logic [TICK_BITS-1:0] age;
		r.hit         = 1'b0;
		r.slot        = '0;
		r.evicted     = 1'b0;
		r.evicted_key = '0;
		r.status      = STATUS_OK;
		found         = -1;
		for (int i = POOL_DEPTH - 1; i >= 0; i--) begin
			if (pool_valid[i] && pool_key[i] == k) found = i;
		end
		if (found >= 0) begin
			// A present key is touched by both operations.
			pool_tick = pool_tick + 1'b1;
			pool_stamp[found] = pool_tick;
			if (op == OP_INSERT) pool_pinned[found] = pool_pinned[found] | p;
			r.hit  = 1'b1;
			r.slot = 4'(found);
		end else if (op == OP_LOOKUP) begin
			r.status = STATUS_MISS;
		end else begin
			// A new key takes the lowest free slot, else the oldest unpinned entry.
			for (int i = POOL_DEPTH - 1; i >= 0; i--) begin
				if (!pool_valid[i]) found = i;
			end
			if (found < 0) begin
				victim = -1;
				oldest = '0;
				for (int i = 0; i < POOL_DEPTH; i++) begin
					age = pool_stamp[i] - oldest;
					if (pool_valid[i] && !pool_pinned[i] && (victim < 0 || age >= TICK_HALF)) begin
						victim = i;
						oldest = pool_stamp[i];
					end
				end
				if (victim >= 0) begin
					r.evicted     = 1'b1;
					r.evicted_key = pool_key[victim];
					found         = victim;
				end
			end
			if (found < 0) begin
				r.status = STATUS_REFUSED;
			end else begin
				pool_valid[found]  = 1'b1;
				pool_key[found]    = k;
				pool_pinned[found] = p;
				pool_tick          = pool_tick + 1'b1;
				pool_stamp[found]  = pool_tick;
				r.slot             = 4'(found);
			end
		end
		return r;
	endfunction

	function automatic logic [KEY_BITS-1:0] rand_key();
		return {$urandom(), $urandom()};
	endfunction

	// Queue a command word with an idle gap: mostly short, a few long.
	task automatic add_cmd(logic op, logic [KEY_BITS-1:0] k, logic p);
		cmd_t c;
		int   r;
		r     = $urandom_range(0, 99);
		c.op  = op;
		c.key = k;
		c.pin = p;
		if (no_idle || r < 35) c.gap = 0;
		else if (r < 85) c.gap = $urandom_range(1, 22);
		else c.gap = $urandom_range(23, 80);
		cmd_queue = {cmd_queue, c};
	endtask

	// Put the next queued word on the command ports.
	task automatic launch_next();
		cmd_t c;
		c = cmd_queue.pop_front();
		start     <= 1'b1;
		operation <= c.op;
		key       <= c.key;
		pin       <= c.pin;
	endtask

	// Driver: predicts each accepted word and presents the next one after its gap.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start     <= 1'b0;
			operation <= OP_LOOKUP;
			key       <= '0;
			pin       <= 1'b0;
			idle_left <= 0;
		end else if (start && !busy) begin
			awaited_results = {awaited_results, pool_access(operation, key, pin)};
			n_accepted++;
			if (cmd_queue.size() != 0 && cmd_queue[0].gap == 0) begin
				launch_next();
			end else begin
				start <= 1'b0;
				if (cmd_queue.size() != 0) idle_left <= cmd_queue[0].gap - 1;
			end
		end else if (!start) begin
			if (idle_left > 0) idle_left <= idle_left - 1;
			else if (cmd_queue.size() != 0) launch_next();
		end
	end

	// Monitor: compares every result word with the oldest prediction.
	always @(posedge clk) begin : check_proc
		result_t w;
		if (arst_n && done) begin
			if (hit) n_hits++;
			if (status == STATUS_MISS) n_misses++;
			if (evicted) n_evictions++;
			if (status == STATUS_REFUSED) n_refused++;
			if (awaited_results.size() == 0) begin
				$display("%0t: unexpected result word: hit=%0b slot=%0d evicted=%0b key=%h status=%0d",
					$time, hit, slot, evicted, evicted_key, status);
				n_errors++;
			end else begin
				w = awaited_results.pop_front();
				if (hit !== w.hit) begin
					$display("%0t: hit expected %0b, actual %0b", $time, w.hit, hit);
					n_errors++;
				end
				if (slot !== w.slot) begin
					$display("%0t: slot expected %0d, actual %0d", $time, w.slot, slot);
					n_errors++;
				end
				if (evicted !== w.evicted) begin
					$display("%0t: evicted expected %0b, actual %0b", $time, w.evicted, evicted);
					n_errors++;
				end
				if (evicted_key !== w.evicted_key) begin
					$display("%0t: evicted_key expected %h, actual %h",
						$time, w.evicted_key, evicted_key);
					n_errors++;
				end
				if (status !== w.status) begin
					$display("%0t: status expected %0d, actual %0d", $time, w.status, status);
					n_errors++;
				end
			end
		end
	end

	// Watchdog against a hung handshake.
	always @(posedge clk) begin
		n_cycles++;
		if (n_cycles == CYCLE_LIMIT) begin
			$display("Timeout after %0d cycles with %0d words accepted", n_cycles, n_accepted);
			$display("== FAIL ==");
			$finish;
		end
	end

	// Stimulus, reset and end of run.
	initial begin : main_proc
		logic [KEY_BITS-1:0] wset [WSET];
		logic [KEY_BITS-1:0] fill_keys [14];
		logic [KEY_BITS-1:0] k;
		logic                op;
		logic                p;

		for (int i = 0; i < POOL_DEPTH; i++) begin
			pool_valid[i]  = 1'b0;
			pool_key[i]    = '0;
			pool_stamp[i]  = '0;
			pool_pinned[i] = 1'b0;
		end
		pool_tick = '0;

		// Directed: extreme keys, misses, hits, a refresh, a full pool and evictions.
		add_cmd(OP_LOOKUP, '0, 1'b1);
		add_cmd(OP_INSERT, '0, 1'b0);
		add_cmd(OP_INSERT, '1, 1'b0);
		add_cmd(OP_LOOKUP, '1, 1'b0);
		add_cmd(OP_LOOKUP, '0, 1'b1);
		add_cmd(OP_INSERT, '0, 1'b0);
		add_cmd(OP_LOOKUP, 64'h8000_0000_0000_0000, 1'b0);
		for (int i = 0; i < 14; i++) begin
			if (i == 0) fill_keys[i] = 64'h5555_5555_5555_5555;
			else if (i == 1) fill_keys[i] = 64'hAAAA_AAAA_AAAA_AAAA;
			else fill_keys[i] = rand_key();
			add_cmd(OP_INSERT, fill_keys[i], 1'b0);
		end
		// The pool is full: the oldest entry goes, then a touched one is spared.
		add_cmd(OP_INSERT, rand_key(), 1'b0);
		add_cmd(OP_LOOKUP, fill_keys[0], 1'b0);
		add_cmd(OP_INSERT, rand_key(), 1'b0);
		add_cmd(OP_LOOKUP, '1, 1'b0);

		// Random traffic over a working set a little larger than the pool, pinned only late.
		wset[0] = '0;
		wset[1] = '1;
		for (int i = 2; i < WSET; i++) wset[i] = rand_key();
		for (int i = 0; i < RANDOM_WORDS + PIN_WORDS; i++) begin
			no_idle = ((i / 100) % 4 == 3);
			if ($urandom_range(0, 19) == 0) wset[$urandom_range(2, WSET - 1)] = rand_key();
			k  = ($urandom_range(0, 9) == 0) ? rand_key() : wset[$urandom_range(0, WSET - 1)];
			op = ($urandom_range(0, 99) < 55) ? OP_INSERT : OP_LOOKUP;
			// Pins are permanent, so they only appear late in the run.
			if (op == OP_LOOKUP) p = 1'($urandom_range(0, 1));
			else if (i >= RANDOM_WORDS) p = ($urandom_range(0, 7) == 0);
			else p = 1'b0;
			add_cmd(op, k, p);
		end

		// Pin every slot, then mixed traffic that meets refused inserts.
		no_idle = 1'b0;
		for (int i = 0; i < POOL_DEPTH; i++) add_cmd(OP_INSERT, rand_key(), 1'b1);
		for (int i = 0; i < 30; i++) begin
			k  = ($urandom_range(0, 2) == 0) ? rand_key() : wset[$urandom_range(0, WSET - 1)];
			op = 1'($urandom_range(0, 1));
			add_cmd(op, k, 1'($urandom_range(0, 1)));
		end

		repeat (11) @(posedge clk);
		@(negedge clk) arst_n = 1'b1;

		while (cmd_queue.size() != 0 || start) @(posedge clk);
		while (awaited_results.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Sent %0d lookup and insert words over %0d cycles.", n_accepted, n_cycles);
		$display("Results seen: %0d hits, %0d lookup misses, %0d evictions, %0d refused inserts.",
			n_hits, n_misses, n_evictions, n_refused);
		if (n_errors == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end

endmodule
